// File: src/bank_switch_mapper_with_line_irq_defines.svh
// ----------------------------------------------------------------------------
// bank switch mapper assertion macros
// shared helpers for concurrent checks on the mapper sequencer
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_WITH_LINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_WITH_LINE_IRQ_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mapper check failed");

// next-cycle implication, sampled on clk, off during reset
`define BSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mapper check failed");

`endif

// File: src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types and codes of the bank switch mapper
// ----------------------------------------------------------------------------
package bsm_pkg;

  // field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int TGT_W   = 3;
  localparam int MAP_W   = 22;
  localparam int BANK_W  = 9;
  localparam int DIVR_W  = 11;
  localparam int CFG_IDX_W = 2;

  // input operation codes
  localparam logic [OP_W-1:0] OP_CPU_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_CPU_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_PPU_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_PPU_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_LINE_TICK = 3'd4;

  // target memory codes
  localparam logic [TGT_W-1:0] TGT_NONE    = 3'd0;
  localparam logic [TGT_W-1:0] TGT_PRG_ROM = 3'd1;
  localparam logic [TGT_W-1:0] TGT_PRG_RAM = 3'd2;
  localparam logic [TGT_W-1:0] TGT_CHR_ROM = 3'd3;
  localparam logic [TGT_W-1:0] TGT_CHR_RAM = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_UNITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRRORING = 2'd2;

  // configuration reset values
  localparam logic [7:0] PRG_UNITS_RST = 8'd2;
  localparam logic [7:0] CHR_UNITS_RST = 8'd1;
  localparam logic       MIRRORING_RST = 1'b0;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [7:0]        dividend;
    logic [DIVR_W-1:0] divisor;
  } rem_req_t;

  // response from the remainder unit
  typedef struct packed {
    logic       done;
    logic [7:0] remainder;
  } rem_rsp_t;

endpackage

// File: src/bank_switch_mapper_with_line_irq.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_line_irq
// cartridge bank mapper with scanline interrupt counter
// ----------------------------------------------------------------------------
// Input channel in_*: tuser carries the operation (cpu read/write, ppu
// read/write, scanline tick), tdata the bus address and write byte. Each
// transfer yields exactly one result on out_*: tuser is the target memory,
// tdata the byte offset in it plus current mirroring and interrupt level.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), to be
// used only while the mapper is idle; the block itself does not enforce it.
// An item that needs no bank modulo passes the execute and push steps only;
// switchable program ROM windows and character ROM reads go through the shared
// eight-step remainder unit before the push step. No new item is taken
// until the result of the last one is loaded, so the sequencer and the
// remainder unit pace the input.
// A finished result sits in the output register; a stalled receiver holds
// the sequencer in its final step until that register frees up, while the
// register itself lets the next item in as soon as it is loaded.
// Reset (rst_n low at a clock edge) clears all mapper state and restores
// the default configuration: 2 program units, 1 character unit, horizontal.
// ----------------------------------------------------------------------------
`include "bank_switch_mapper_with_line_irq_defines.svh"

module bank_switch_mapper_with_line_irq
  import bsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // address[15:0], write_data[23:16]
  input  logic [OP_W-1:0]      in_tuser,   // opcode[2:0]
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // mapped_address[21:0],
                                           // mirroring_vertical[22], irq_flag[23]
  output logic [TGT_W-1:0]     out_tuser,  // target[2:0]
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]        state_r;

  // configuration
  logic [7:0]        prg_units_r;
  logic [7:0]        chr_units_r;

  // mapper state
  logic [2:0]        bank_sel_r;
  logic              prg_swap_r;
  logic              chr_swap_r;
  logic [7:0]        bank_regs_r [8];
  logic              mirr_r;
  logic [7:0]        line_latch_r;
  logic [7:0]        line_cnt_r;
  logic              reload_r;
  logic              irq_en_r;
  logic              irq_pend_r;

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;

  // per-item result held between steps
  logic [TGT_W-1:0]  tgt_r;
  logic [BANK_W-1:0] bank_r;

  // output register
  logic              out_valid_r;
  logic [TGT_W-1:0]  out_tgt_r;
  logic [MAP_W-1:0]  out_addr_r;
  logic              out_mirr_r;
  logic              out_irq_r;

  logic              in_xfer;
  logic              out_free;

  // decode of the captured item
  logic [BANK_W-1:0] prg_banks;
  logic [DIVR_W-1:0] div_count;
  logic              is_prg_ram;
  logic [2:0]        chr_slot;
  logic [2:0]        chr_idx;
  logic [7:0]        slot_bank;
  logic [TGT_W-1:0]  ex_tgt;
  logic              ex_mod;
  logic [7:0]        ex_dividend;
  logic [BANK_W-1:0] ex_bank;
  logic [7:0]        tick_cnt;
  logic [MAP_W-1:0]  map_addr;
  logic [DIVR_W-1:0] rem_ext;

  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // bank counts and window decode
  assign prg_banks  = {prg_units_r, 1'b0};
  assign div_count  = (op_r == OP_PPU_READ) ? {chr_units_r, 3'b000}
                                            : {2'b00, prg_banks};
  assign is_prg_ram = (addr_r[15:13] == 3'b011);
  assign chr_slot   = addr_r[12:10] ^ {chr_swap_r, 2'b00};
  assign chr_idx    = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
  assign slot_bank  = chr_slot[2] ? bank_regs_r[chr_idx]
                                  : {bank_regs_r[chr_idx][7:1], chr_slot[0]};

  // target, direct bank or modulo request for the captured item
  always_comb begin
    ex_tgt      = TGT_NONE;
    ex_mod      = 1'b0;
    ex_dividend = '0;
    ex_bank     = '0;
    case (op_r)
      OP_CPU_READ: begin
        if (is_prg_ram) begin
          ex_tgt = TGT_PRG_RAM;
        end else if (addr_r[15] && (prg_units_r != 8'd0)) begin
          ex_tgt = TGT_PRG_ROM;
          case (addr_r[14:13])
            2'd0: begin
              if (prg_swap_r) begin
                ex_bank = prg_banks - 9'd2;
              end else begin
                ex_mod      = 1'b1;
                ex_dividend = bank_regs_r[6];
              end
            end
            2'd1: begin
              ex_mod      = 1'b1;
              ex_dividend = bank_regs_r[7];
            end
            2'd2: begin
              if (prg_swap_r) begin
                ex_mod      = 1'b1;
                ex_dividend = bank_regs_r[6];
              end else begin
                ex_bank = prg_banks - 9'd2;
              end
            end
            default: ex_bank = prg_banks - 9'd1;
          endcase
        end
      end
      OP_CPU_WRITE: begin
        if (is_prg_ram) begin
          ex_tgt = TGT_PRG_RAM;
        end
      end
      OP_PPU_READ: begin
        if (chr_units_r == 8'd0) begin
          ex_tgt = TGT_CHR_RAM;
        end else begin
          ex_tgt      = TGT_CHR_ROM;
          ex_mod      = 1'b1;
          ex_dividend = slot_bank;
        end
      end
      OP_PPU_WRITE: begin
        if (chr_units_r == 8'd0) begin
          ex_tgt = TGT_CHR_RAM;
        end
      end
      default: ex_tgt = TGT_NONE;
    endcase
  end

  // scanline counter next value
  assign tick_cnt = ((line_cnt_r == 8'd0) || reload_r) ? line_latch_r
                                                       : (line_cnt_r - 8'd1);

  // remainder unit
  assign rem_req.start    = (state_r == S_EXEC) && ex_mod;
  assign rem_req.dividend = ex_dividend;
  assign rem_req.divisor  = div_count;

  bsm_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign rem_ext = {3'b000, rem_rsp.remainder};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_xfer) state_r <= S_EXEC;
        S_EXEC: state_r <= ex_mod ? S_DIV : S_PUSH;
        S_DIV:  if (rem_rsp.done) state_r <= S_PUSH;
        S_PUSH: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item capture and per-item result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[15:0];
      data_r <= in_tdata[23:16];
    end
    if (state_r == S_EXEC) begin
      tgt_r  <= ex_tgt;
      bank_r <= ex_bank;
    end else if ((state_r == S_DIV) && rem_rsp.done) begin
      bank_r <= {1'b0, rem_rsp.remainder};
    end
  end

  // configuration and mapper registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_units_r  <= PRG_UNITS_RST;
      chr_units_r  <= CHR_UNITS_RST;
      mirr_r       <= MIRRORING_RST;
      bank_sel_r   <= '0;
      prg_swap_r   <= 1'b0;
      chr_swap_r   <= 1'b0;
      bank_regs_r  <= '{default: 8'd0};
      line_latch_r <= '0;
      line_cnt_r   <= '0;
      reload_r     <= 1'b0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRG_UNITS: prg_units_r <= cfg_wdata;
          CFG_CHR_UNITS: chr_units_r <= cfg_wdata;
          CFG_MIRRORING: mirr_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == S_EXEC) begin
        // register writes in the upper cpu half
        if ((op_r == OP_CPU_WRITE) && addr_r[15]) begin
          case (addr_r[14:13])
            2'd0: begin
              if (!addr_r[0]) begin
                bank_sel_r <= data_r[2:0];
                prg_swap_r <= data_r[6];
                chr_swap_r <= data_r[7];
              end else begin
                bank_regs_r[bank_sel_r] <= data_r;
              end
            end
            2'd1: if (!addr_r[0]) mirr_r <= !data_r[0];
            2'd2: begin
              if (!addr_r[0]) begin
                line_latch_r <= data_r;
              end else begin
                reload_r <= 1'b1;
              end
            end
            default: begin
              if (!addr_r[0]) begin
                irq_en_r   <= 1'b0;
                irq_pend_r <= 1'b0;
              end else begin
                irq_en_r <= 1'b1;
              end
            end
          endcase
        end
        // scanline tick
        if (op_r == OP_LINE_TICK) begin
          line_cnt_r <= tick_cnt;
          reload_r   <= 1'b0;
          if ((tick_cnt == 8'd0) && irq_en_r) begin
            irq_pend_r <= 1'b1;
          end
        end
      end
    end
  end

  // offset inside the target memory
  always_comb begin
    case (tgt_r)
      TGT_PRG_ROM: map_addr = {bank_r, addr_r[12:0]};
      TGT_PRG_RAM: map_addr = {9'd0, addr_r[12:0]};
      TGT_CHR_RAM: map_addr = {9'd0, addr_r[12:0]};
      TGT_CHR_ROM: map_addr = {3'd0, bank_r, addr_r[9:0]};
      default:     map_addr = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_PUSH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_PUSH) && out_free) begin
      out_tgt_r  <= tgt_r;
      out_addr_r <= map_addr;
      out_mirr_r <= mirr_r;
      out_irq_r  <= irq_pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tgt_r;
  assign out_tdata  = {out_irq_r, out_mirr_r, out_addr_r};

  // checks
  `BSM_ASSERT_NXT(a_accept_exec, in_xfer, state_r == S_EXEC)
  `BSM_ASSERT_IMP(a_done_in_div, rem_rsp.done, state_r == S_DIV)
  `BSM_ASSERT_IMP(a_rem_range, rem_rsp.done, rem_ext < div_count)
  `BSM_ASSERT_IMP(a_none_zero, out_valid_r && (out_tgt_r == TGT_NONE), out_addr_r == '0)

endmodule

// File: src/bsm_rem.sv
// ----------------------------------------------------------------------------
// bsm_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bsm_rem
  import bsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [2:0]        cnt_r;
  logic [7:0]        rem_r;
  logic [7:0]        dvd_r;
  logic [DIVR_W-1:0] divr_r;

  logic [8:0]        trial;
  logic [DIVR_W-1:0] trial_ext;
  logic [DIVR_W-1:0] diff;
  logic [7:0]        rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  assign trial     = {rem_r, dvd_r[7]};
  assign trial_ext = {{(DIVR_W-9){1'b0}}, trial};
  assign diff      = trial_ext - divr_r;
  assign rem_nxt   = (trial_ext >= divr_r) ? diff[7:0] : trial[7:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd7);
      if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      dvd_r  <= req.dividend;
      divr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[6:0], 1'b0};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

// File: test/bank_switch_mapper_with_line_irq_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_line_irq_tb
// self-checking bench for the cartridge bank mapper: cpu and ppu accesses,
// register writes and scanline ticks go in over the input stream, and every
// result is compared against a cycle-free shadow of the mapper state.
// Directed cases cover window edges, swap modes and the line interrupt.
// Random phases then run under several cartridge size settings, with
// random idle gaps on both streams.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_line_irq_tb;
  import bsm_pkg::*;

  // opcodes the mapper ignores
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  // cpu addresses: low space, prg ram and the mapper register pairs
  localparam logic [15:0] A_LOW_SPACE  = 16'h5FFF;
  localparam logic [15:0] A_PRG_RAM    = 16'h6000;
  localparam logic [15:0] A_BANK_SEL   = 16'h8000;
  localparam logic [15:0] A_BANK_DATA  = 16'h8001;
  localparam logic [15:0] A_MIRROR     = 16'hA000;
  localparam logic [15:0] A_PROTECT    = 16'hA001;
  localparam logic [15:0] A_IRQ_LATCH  = 16'hC000;
  localparam logic [15:0] A_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] A_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] A_IRQ_ON     = 16'hE001;

  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic [MAP_W-1:0] offset;
    logic             mirror_v;
    logic             irq;
  } bus_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;   // address[15:0], write_data[23:16]
  logic [OP_W-1:0]      in_tuser = '0;   // opcode[2:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;       // mapped_address[21:0], mirroring_vertical[22],
                                         // irq_flag[23]
  logic [TGT_W-1:0]     out_tuser;       // target[2:0]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  // shadow of configuration and mapper state
  logic [7:0] prg_units, chr_units;
  logic [2:0] sel_q;
  logic       prg_swap, chr_swap;
  logic [7:0] bank_q [8];
  logic       mirror_v_q;
  logic [7:0] line_latch_q, line_count_q;
  logic       reload_q, irq_en_q, irq_q;

  bus_result_t mapped_q [$];

  int unsigned n_items, n_results, n_configs, fail_count;
  int unsigned stall_left;
  bit          steady;

  bank_switch_mapper_with_line_irq u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mapper state after reset
  function automatic void reset_shadow();
    prg_units    = PRG_UNITS_RST;
    chr_units    = CHR_UNITS_RST;
    sel_q        = '0;
    prg_swap     = 1'b0;
    chr_swap     = 1'b0;
    for (int i = 0; i < 8; i++) bank_q[i] = '0;
    mirror_v_q   = MIRRORING_RST;
    line_latch_q = '0;
    line_count_q = '0;
    reload_q     = 1'b0;
    irq_en_q     = 1'b0;
    irq_q        = 1'b0;
  endfunction

  // expected result of one bus event, updating the shadow state
  function automatic bus_result_t map_bus_event(input logic [OP_W-1:0] op,
                                                input logic [15:0] a, input logic [7:0] d);
    bus_result_t  r;
    int unsigned  count, bank;
    logic [2:0]   slot;
    r = '0;
    case (op)
      OP_CPU_READ, OP_CPU_WRITE: begin
        if (a >= A_PRG_RAM && !a[15]) begin
          r.target = TGT_PRG_RAM;
          r.offset = MAP_W'(a - A_PRG_RAM);
        end else if (a[15] && op == OP_CPU_READ) begin
          // 8k program windows, the last fixed to the top bank, window 0 or 2 to the one below
          count = 2 * prg_units;
          if (count != 0) begin
            case (a[14:13])
              2'b00:   bank = prg_swap ? count - 2 : bank_q[6] % count;
              2'b01:   bank = bank_q[7] % count;
              2'b10:   bank = prg_swap ? bank_q[6] % count : count - 2;
              default: bank = count - 1;
            endcase
            r.target = TGT_PRG_ROM;
            r.offset = MAP_W'(bank * 'h2000 + a[12:0]);
          end
        end else if (a[15]) begin
          // register writes, even and odd address pairs
          case (a[14:13])
            2'b00: begin
              if (!a[0]) begin
                sel_q    = d[2:0];
                prg_swap = d[6];
                chr_swap = d[7];
              end else begin
                bank_q[sel_q] = d;
              end
            end
            2'b01: if (!a[0]) mirror_v_q = ~d[0];
            2'b10: begin
              if (!a[0]) line_latch_q = d;
              else reload_q = 1'b1;
            end
            default: begin
              if (!a[0]) begin
                irq_en_q = 1'b0;
                irq_q    = 1'b0;
              end else begin
                irq_en_q = 1'b1;
              end
            end
          endcase
        end
      end
      OP_PPU_READ: begin
        if (chr_units == 0) begin
          r.target = TGT_CHR_RAM;
          r.offset = MAP_W'(a[12:0]);
        end else begin
          // 2k pairs in the low half, 1k banks in the high half
          slot = a[12:10] ^ {chr_swap, 2'b00};
          if (!slot[2]) bank = {bank_q[slot[1]][7:1], slot[0]};
          else bank = bank_q[slot - 3'd2];
          bank = bank % (8 * chr_units);
          r.target = TGT_CHR_ROM;
          r.offset = MAP_W'(bank * 'h400 + a[9:0]);
        end
      end
      OP_PPU_WRITE: begin
        if (chr_units == 0) begin
          r.target = TGT_CHR_RAM;
          r.offset = MAP_W'(a[12:0]);
        end
      end
      OP_LINE_TICK: begin
        if (line_count_q == 0 || reload_q) begin
          line_count_q = line_latch_q;
          reload_q     = 1'b0;
        end else begin
          line_count_q = line_count_q - 8'd1;
        end
        if (line_count_q == 0 && irq_en_q) irq_q = 1'b1;
      end
      default: ;
    endcase
    r.mirror_v = mirror_v_q;
    r.irq      = irq_q;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one transfer on the input stream, expectation queued on acceptance
  task automatic send_access(input logic [OP_W-1:0] op, input logic [15:0] a,
                             input logic [7:0] d);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {d, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mapped_q.push_back(map_bus_event(op, a, d));
    n_items++;
  endtask

  // wait until every expected result has been seen
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
  endtask

  // all three cartridge settings, written while idle
  task automatic set_config(input logic [7:0] prg, input logic [7:0] chr, input logic mir);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_UNITS;
    cfg_wdata <= prg;
    @(posedge clk);
    cfg_index <= CFG_CHR_UNITS;
    cfg_wdata <= chr;
    @(posedge clk);
    cfg_index <= CFG_MIRRORING;
    cfg_wdata <= {7'd0, mir};
    @(posedge clk);
    cfg_we     <= 1'b0;
    prg_units  = prg;
    chr_units  = chr;
    mirror_v_q = mir;
    n_configs++;
  endtask

  task automatic write_bank(input logic [2:0] idx, input logic [7:0] val,
                            input logic chr_inv, input logic prg_inv);
    send_access(OP_CPU_WRITE, A_BANK_SEL, {chr_inv, prg_inv, 3'b000, idx});
    send_access(OP_CPU_WRITE, A_BANK_DATA, val);
  endtask

  // program space windows, prg ram, low space and ignored opcodes
  task automatic test_cpu_space();
    send_access(OP_CPU_READ, 16'h0000, 8'h00);
    send_access(OP_CPU_WRITE, A_LOW_SPACE, 8'hFF);
    send_access(OP_CPU_READ, A_PRG_RAM, 8'h00);
    send_access(OP_CPU_WRITE, 16'h7FFF, 8'hA5);
    send_access(OP_CPU_READ, 16'h8000, 8'h00);
    send_access(OP_CPU_READ, 16'hBFFF, 8'h00);
    send_access(OP_CPU_READ, 16'hC000, 8'h00);
    send_access(OP_CPU_READ, 16'hFFFF, 8'h00);
    write_bank(3'd6, 8'hFF, 1'b0, 1'b1);
    write_bank(3'd7, 8'h03, 1'b0, 1'b1);
    send_access(OP_CPU_READ, 16'h8123, 8'h00);
    send_access(OP_CPU_READ, 16'hA000, 8'h00);
    send_access(OP_CPU_READ, 16'hDFFF, 8'h00);
    send_access(OP_CPU_READ, 16'hE000, 8'h00);
    send_access(OP_CPU_WRITE, A_MIRROR, 8'hFE);
    send_access(OP_CPU_WRITE, A_MIRROR, 8'h01);
    send_access(OP_CPU_WRITE, A_PROTECT, 8'hC0);
    for (int k = OP_RSVD_FIRST; k <= OP_RSVD_LAST; k++)
      send_access(OP_W'(k), 16'hFFFF, 8'hFF);
  endtask

  // pattern space slots, both swap modes, rom write ignored
  task automatic test_chr_space();
    write_bank(3'd0, 8'hFF, 1'b0, 1'b0);
    write_bank(3'd1, 8'h12, 1'b0, 1'b0);
    write_bank(3'd2, 8'h05, 1'b0, 1'b0);
    write_bank(3'd5, 8'h07, 1'b0, 1'b0);
    for (int s = 0; s < 8; s++)
      send_access(OP_PPU_READ, 16'(s * 'h400 + 'h155), 8'h00);
    send_access(OP_PPU_READ, 16'hFFFF, 8'hFF);
    send_access(OP_PPU_WRITE, 16'h1FFF, 8'hFF);
    write_bank(3'd3, 8'h06, 1'b1, 1'b0);
    send_access(OP_PPU_READ, 16'h0000, 8'h00);
    send_access(OP_PPU_READ, 16'h0C00, 8'h00);
    send_access(OP_PPU_READ, 16'h1000, 8'h00);
    send_access(OP_PPU_READ, 16'h1FFF, 8'h00);
  endtask

  // scanline counter: reload, count down, assert, acknowledge, zero latch
  task automatic test_line_irq();
    send_access(OP_CPU_WRITE, A_IRQ_LATCH, 8'h02);
    send_access(OP_CPU_WRITE, A_IRQ_RELOAD, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_ON, 8'h00);
    repeat (4) send_access(OP_LINE_TICK, 16'h0000, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_OFF, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_ON, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_LATCH, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_RELOAD, 8'hFF);
    repeat (2) send_access(OP_LINE_TICK, 16'hFFFF, 8'hFF);
    send_access(OP_CPU_WRITE, A_IRQ_OFF, 8'h00);
    send_access(OP_LINE_TICK, 16'h0000, 8'h00);
    send_access(OP_CPU_WRITE, A_IRQ_LATCH, 8'hFF);
    send_access(OP_CPU_WRITE, A_IRQ_RELOAD, 8'h00);
    send_access(OP_LINE_TICK, 16'h0000, 8'h00);
  endtask

  // no rom at all, largest sizes, non power of two bank counts
  task automatic test_config_extremes();
    set_config(8'd0, 8'd0, 1'b1);
    send_access(OP_CPU_READ, 16'h8000, 8'h00);
    send_access(OP_CPU_READ, 16'hFFFF, 8'h00);
    send_access(OP_CPU_READ, A_PRG_RAM, 8'h00);
    send_access(OP_PPU_READ, 16'h1ABC, 8'h00);
    send_access(OP_PPU_WRITE, 16'hFFFF, 8'hFF);
    send_access(OP_CPU_WRITE, A_MIRROR, 8'h00);
    set_config(8'd255, 8'd255, 1'b0);
    write_bank(3'd6, 8'hFF, 1'b0, 1'b0);
    write_bank(3'd4, 8'hFF, 1'b0, 1'b0);
    send_access(OP_CPU_READ, 16'h9FFF, 8'h00);
    send_access(OP_CPU_READ, 16'hC000, 8'h00);
    send_access(OP_CPU_READ, 16'hFFFF, 8'h00);
    send_access(OP_PPU_READ, 16'h1BFF, 8'h00);
    set_config(8'd1, 8'd3, 1'b1);
    send_access(OP_CPU_READ, 16'h8000, 8'h00);
    send_access(OP_CPU_READ, 16'hE001, 8'h00);
    send_access(OP_PPU_READ, 16'h1800, 8'h00);
    send_access(OP_PPU_READ, 16'h0400, 8'h00);
  endtask

  // one random event of any kind
  task automatic random_access();
    logic [OP_W-1:0] op;
    logic [15:0]     a;
    logic [7:0]      d;
    int unsigned     r;
    r = $urandom_range(0, 99);
    if (r < 28) op = OP_CPU_READ;
    else if (r < 50) op = OP_CPU_WRITE;
    else if (r < 75) op = OP_PPU_READ;
    else if (r < 83) op = OP_PPU_WRITE;
    else if (r < 97) op = OP_LINE_TICK;
    else op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    a = 16'($urandom);
    d = 8'($urandom);
    if ((op == OP_CPU_READ || op == OP_CPU_WRITE) && $urandom_range(0, 3) != 0)
      a = 16'($urandom_range(A_PRG_RAM, 16'hFFFF));
    send_access(op, a, d);
  endtask

  // bank select and data pair followed by reads through the new mapping
  task automatic bank_burst();
    logic [11:0] r12;
    r12 = 12'($urandom);
    send_access(OP_CPU_WRITE, {3'b100, r12, 1'b0}, 8'($urandom));
    send_access(OP_CPU_WRITE, {3'b100, ~r12, 1'b1}, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0)
        send_access(OP_CPU_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
      else
        send_access(OP_PPU_READ, 16'($urandom), 8'($urandom));
    end
  endtask

  // short latch, reload, enable, then ticks mixed with other traffic
  task automatic irq_burst();
    logic [11:0] r12;
    r12 = 12'($urandom);
    send_access(OP_CPU_WRITE, {3'b110, r12, 1'b0}, 8'($urandom_range(0, 6)));
    send_access(OP_CPU_WRITE, {3'b110, ~r12, 1'b1}, 8'($urandom));
    send_access(OP_CPU_WRITE, {3'b111, r12, 1'b1}, 8'($urandom));
    repeat ($urandom_range(3, 12)) begin
      send_access(OP_LINE_TICK, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0) random_access();
      if ($urandom_range(0, 5) == 0) begin
        send_access(OP_CPU_WRITE, {3'b111, ~r12, 1'b0}, 8'($urandom));
        send_access(OP_CPU_WRITE, {3'b111, r12, 1'b1}, 8'($urandom));
      end
    end
  endtask

  // random traffic under one cartridge setting
  task automatic test_random_phase(input logic [7:0] prg, input logic [7:0] chr,
                                   input logic mir, input bit no_idle,
                                   input int unsigned items);
    int unsigned stop_at;
    set_config(prg, chr, mir);
    steady  = no_idle;
    stop_at = n_items + items;
    while (n_items < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1:    bank_burst();
        2:       irq_burst();
        default: random_access();
      endcase
    end
    steady = 1'b0;
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_field(input string what, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (mapped_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual target %0h tdata %0h",
                 $time, out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = mapped_q.pop_front();
        report_field("target", want.target, out_tuser);
        report_field("mapped_address", want.offset, out_tdata[21:0]);
        report_field("mirroring_vertical", want.mirror_v, out_tdata[22]);
        report_field("irq_flag", want.irq, out_tdata[23]);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still expected", $time, mapped_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_cpu_space();
    test_chr_space();
    test_line_irq();
    test_config_extremes();
    test_random_phase(PRG_UNITS_RST, CHR_UNITS_RST, MIRRORING_RST, 1'b0, 300);
    test_random_phase(8'd255, 8'd255, 1'b1, 1'b0, 300);
    test_random_phase(8'd0, 8'd0, 1'b0, 1'b0, 300);
    test_random_phase(8'd1, 8'd3, 1'b1, 1'b1, 300);
    test_random_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom), 1'b0, 300);
    test_random_phase(8'd2, 8'd0, 1'b1, 1'b0, 300);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d bus events, checked %0d results over %0d cartridge settings",
             n_items, n_results, n_configs);
    $display("covered cpu/ppu mapping, register writes, line interrupt and ignored opcodes");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
